// ===== src/sgm_pkg.sv =====
// shared types and constants for the sgm path cost aggregation block
// no dependencies
`default_nettype none

package sgm_pkg;

  localparam int RAW_W   = 8;
  localparam int COST_W  = 11;
  localparam int P1_W    = 8;
  localparam int P2_W    = 10;
  localparam int IDX_W   = 6;
  localparam int CFG_A_W = 1;
  localparam int CFG_D_W = 10;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    REG_PENALTY_SMALL = 1'b0,
    REG_PENALTY_LARGE = 1'b1
  } cfg_reg_t;

  // one result transaction
  typedef struct packed {
    logic [COST_W-1:0] path_cost;
    logic [IDX_W-1:0]  disparity_index;
    logic              pixel_done;
  } out_item_t;

  // control flags handed to the cost unit
  typedef struct packed {
    logic              is_start;
    logic              first;
    logic              last;
  } cost_ctl_t;

endpackage

`default_nettype wire

// ===== src/sgm_stream_if.sv =====
// stream interfaces for raw costs in and path costs out
// depends on sgm_pkg
`default_nettype none

interface sgm_raw_if;
  logic                      valid;
  logic                      ready;
  logic [sgm_pkg::RAW_W-1:0] match_cost;
  logic                      path_start;

  modport source (output valid, output match_cost, output path_start, input ready);
  modport sink   (input valid, input match_cost, input path_start, output ready);
endinterface

interface sgm_path_if;
  logic                       valid;
  logic                       ready;
  logic [sgm_pkg::COST_W-1:0] path_cost;
  logic [sgm_pkg::IDX_W-1:0]  disparity_index;
  logic                       pixel_done;

  modport source (output valid, output path_cost, output disparity_index,
                  output pixel_done, input ready);
  modport sink   (input valid, input path_cost, input disparity_index,
                  input pixel_done, output ready);
endinterface

`default_nettype wire

// ===== src/sgm_path_cost_aggregation.sv =====
// top level of the sgm path cost aggregation block
// depends on sgm_pkg, sgm_stream_if, sgm_cell, sgm_cost_unit, sgm_out_skid
`default_nettype none

// Aggregates semi-global matching costs along one scan path. Raw costs enter
// one disparity per transaction, disparities 0..NUM_DISP-1 of a pixel in order,
// pixels in path order; each transaction yields exactly one path cost
// transaction, raw + min(prev[d], prev[d-1]+P1, prev[d+1]+P1, prevmin+P2) -
// prevmin, clamped to 11 bits. A pixel whose disparity-zero transaction has
// path_start set passes its raw costs through. The block takes one transaction
// per clock cycle while the output stage has room; results are registered
// there. The predecessor vector lives in a ring of NUM_DISP cells that
// rotates by one place per accepted transaction, so the cost for disparity d
// always reads prev[d] and prev[d+1] from the two head cells. A two-entry
// output stage keeps input ready high while one result waits.
// Penalties are written through wr_en / wr_index / wr_data and should only
// change while the block is idle. The first pixel after reset must be a path
// start.

module sgm_path_cost_aggregation #(
  parameter int NUM_DISP = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic [sgm_pkg::CFG_A_W-1:0] wr_index,
  input  wire logic [sgm_pkg::CFG_D_W-1:0] wr_data,
  sgm_raw_if.sink                          raw_stream,
  sgm_path_if.source                       path_stream
);

  localparam int CNT_W = (NUM_DISP > 2) ? $clog2(NUM_DISP) : 1;
  localparam int CW    = sgm_pkg::COST_W;

  // configuration
  logic [sgm_pkg::P1_W-1:0] penalty_small;
  logic [sgm_pkg::P2_W-1:0] penalty_large;

  always_ff @(posedge clk) begin
    if (rst) begin
      penalty_small <= sgm_pkg::P1_W'(10);
      penalty_large <= sgm_pkg::P2_W'(120);
    end else if (wr_en) begin
      unique case (sgm_pkg::cfg_reg_t'(wr_index))
        sgm_pkg::REG_PENALTY_SMALL: penalty_small <= wr_data[sgm_pkg::P1_W-1:0];
        sgm_pkg::REG_PENALTY_LARGE: penalty_large <= wr_data[sgm_pkg::P2_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic room;
  logic accept;

  assign raw_stream.ready = room;
  assign accept           = raw_stream.valid && room;

  // per-pixel control state
  logic [CNT_W-1:0] disp_cnt;
  logic             pixel_is_start;
  logic [CW-1:0]    held_lower;
  logic [CW-1:0]    last_min;
  logic [CW-1:0]    run_min;

  logic             first;
  logic             last;
  logic             start_now;
  logic [CW-1:0]    cost;
  logic [CW-1:0]    run_min_next;

  assign first     = (disp_cnt == '0);
  assign last      = (disp_cnt == CNT_W'(NUM_DISP - 1));
  assign start_now = first ? raw_stream.path_start : pixel_is_start;

  // ring of predecessor cells; cell 0 holds prev[d], cell 1 holds prev[d+1]
  logic [CW-1:0] ring [NUM_DISP];

  for (genvar i = 0; i < NUM_DISP; i++) begin : g_cell
    logic [CW-1:0] feed;
    if (i == NUM_DISP - 1) begin : g_tail
      // new cost enters at the tail and reaches the head after NUM_DISP shifts
      assign feed = cost;
    end else begin : g_mid
      assign feed = ring[i+1];
    end
    sgm_cell u_cell (
      .clk       (clk),
      .shift     (accept),
      .from_next (feed),
      .value     (ring[i])
    );
  end

  // cost arithmetic
  sgm_pkg::cost_ctl_t ctl;

  assign ctl.is_start = start_now;
  assign ctl.first    = first;
  assign ctl.last     = last;

  sgm_cost_unit u_cost (
    .match_cost (raw_stream.match_cost),
    .ctl        (ctl),
    .prev_here  (ring[0]),
    .prev_above (ring[1]),
    .held_lower (held_lower),
    .last_min   (last_min),
    .p1         (penalty_small),
    .p2         (penalty_large),
    .cost       (cost)
  );

  assign run_min_next = (cost < run_min) ? cost : run_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_cnt       <= '0;
      pixel_is_start <= 1'b0;
      held_lower     <= '0;
      last_min       <= '0;
      run_min        <= sgm_pkg::COST_MAX;
    end else if (accept) begin
      pixel_is_start <= start_now;
      held_lower     <= ring[0];
      if (last) begin
        disp_cnt <= '0;
        last_min <= run_min_next;
        run_min  <= sgm_pkg::COST_MAX;
      end else begin
        disp_cnt <= disp_cnt + CNT_W'(1);
        run_min  <= run_min_next;
      end
    end
  end

  // result transaction; disparity index carries the low bits of the counter
  logic [CNT_W+sgm_pkg::IDX_W-1:0] cnt_ext;
  sgm_pkg::out_item_t              item;

  assign cnt_ext              = (CNT_W + sgm_pkg::IDX_W)'(disp_cnt);
  assign item.path_cost       = cost;
  assign item.disparity_index = cnt_ext[sgm_pkg::IDX_W-1:0];
  assign item.pixel_done      = last;

  sgm_out_skid u_out (
    .clk  (clk),
    .rst  (rst),
    .push (accept),
    .item (item),
    .room (room),
    .path (path_stream)
  );

endmodule

`default_nettype wire

// ===== src/sgm_cell.sv =====
// one stage of the circulating previous-vector line
// depends on sgm_pkg
`default_nettype none

module sgm_cell (
  input  wire logic                       clk,
  input  wire logic                       shift,
  input  wire logic [sgm_pkg::COST_W-1:0] from_next,
  output logic      [sgm_pkg::COST_W-1:0] value
);

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= from_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/sgm_cost_unit.sv =====
// path cost for one disparity from the raw cost and predecessor terms
// depends on sgm_pkg
`default_nettype none

module sgm_cost_unit (
  input  wire logic [sgm_pkg::RAW_W-1:0]  match_cost,
  input  wire sgm_pkg::cost_ctl_t         ctl,
  input  wire logic [sgm_pkg::COST_W-1:0] prev_here,
  input  wire logic [sgm_pkg::COST_W-1:0] prev_above,
  input  wire logic [sgm_pkg::COST_W-1:0] held_lower,
  input  wire logic [sgm_pkg::COST_W-1:0] last_min,
  input  wire logic [sgm_pkg::P1_W-1:0]   p1,
  input  wire logic [sgm_pkg::P2_W-1:0]   p2,
  output logic      [sgm_pkg::COST_W-1:0] cost
);

  localparam int SW = sgm_pkg::COST_W + 1;

  logic [SW-1:0] lower_term;
  logic [SW-1:0] upper_term;
  logic [SW-1:0] jump_term;
  logic [SW-1:0] m;
  logic [SW-1:0] diff;
  logic [SW:0]   total;

  always_comb begin
    lower_term = SW'(held_lower) + SW'(p1);
    upper_term = SW'(prev_above) + SW'(p1);
    jump_term  = SW'(last_min) + SW'(p2);
    m = SW'(prev_here);
    if (!ctl.first && lower_term < m) begin
      m = lower_term;
    end
    if (!ctl.last && upper_term < m) begin
      m = upper_term;
    end
    if (jump_term < m) begin
      m = jump_term;
    end
    // clamp at zero if the minimum ever falls below last_min
    diff  = (m > SW'(last_min)) ? (m - SW'(last_min)) : '0;
    total = (SW+1)'(match_cost) + (SW+1)'(diff);
    if (ctl.is_start) begin
      cost = sgm_pkg::COST_W'(match_cost);
    end else if (total > (SW+1)'(sgm_pkg::COST_MAX)) begin
      cost = sgm_pkg::COST_MAX;
    end else begin
      cost = total[sgm_pkg::COST_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/sgm_out_skid.sv =====
// two-entry output register and skid stage for the path cost stream
// depends on sgm_pkg and sgm_path_if
`default_nettype none

module sgm_out_skid (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire sgm_pkg::out_item_t item,
  output logic                    room,
  sgm_path_if.source              path
);

  sgm_pkg::out_item_t main_q;
  sgm_pkg::out_item_t skid_q;
  logic               main_valid;
  logic               skid_valid;
  logic               pop;

  assign pop  = main_valid && path.ready;
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_q     <= skid_q;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_q     <= item;
        main_valid <= 1'b1;
      end else begin
        skid_q     <= item;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  assign path.valid           = main_valid;
  assign path.path_cost       = main_q.path_cost;
  assign path.disparity_index = main_q.disparity_index;
  assign path.pixel_done      = main_q.pixel_done;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// testbench for sgm_path_cost_aggregation: streams whole pixels of raw costs,
// predicts every path cost in a scoreboard and checks results in order
// depends on sgm_pkg, sgm_stream_if and the rtl of the block
`timescale 1ns / 1ps

module tb;

  localparam int NDISP = 64;

  // pixel profiles used by the stimulus
  typedef enum int {
    SHAPE_UNIFORM,
    SHAPE_VALLEY,
    SHAPE_FLAT,
    SHAPE_ZERO,
    SHAPE_FULL,
    SHAPE_ALTERNATE
  } pixel_shape_t;

  logic                          clk;
  logic                          rst;
  logic                          wr_en;
  logic [sgm_pkg::CFG_A_W-1:0]   wr_index;
  logic [sgm_pkg::CFG_D_W-1:0]   wr_data;

  sgm_raw_if  raw_bus ();
  sgm_path_if path_bus ();

  sgm_path_cost_aggregation #(
    .NUM_DISP (NDISP)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .raw_stream  (raw_bus),
    .path_stream (path_bus)
  );

  // clock: 12 ns period
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // aggregation predictor: own copy of the penalties and the path state
  // ---------------------------------------------------------------------------
  logic [sgm_pkg::P1_W-1:0]   small_penalty;
  logic [sgm_pkg::P2_W-1:0]   large_penalty;
  logic [sgm_pkg::COST_W-1:0] prior_costs [NDISP];
  logic [sgm_pkg::COST_W-1:0] prior_floor;     // minimum of the previous pixel
  logic [sgm_pkg::COST_W-1:0] pixel_floor;     // running minimum of the current pixel
  logic [sgm_pkg::COST_W-1:0] saved_lower;     // old prior_costs[d-1] before overwrite
  int unsigned                disp_pos;
  logic                       start_pixel;

  sgm_pkg::out_item_t expected_costs [$];

  int errors;
  int costs_sent;
  int costs_checked;
  int start_pixels;
  int stall_cycles;

  // run-wide knobs
  bit no_gaps;          // both sides run flat out
  int hold_request;     // receiver hold-off length, picked up by the ready process
  int hold_left;

  task automatic clear_predictor();
    small_penalty = 8'd10;
    large_penalty = 10'd120;
    for (int i = 0; i < NDISP; i++) prior_costs[i] = '0;
    prior_floor = '0;
    pixel_floor = sgm_pkg::COST_MAX;
    saved_lower = '0;
    disp_pos    = 0;
    start_pixel = 1'b0;
  endtask

  // path cost for one accepted raw cost; advances the predicted state
  function automatic sgm_pkg::out_item_t predict_path_cost(
      input logic [sgm_pkg::RAW_W-1:0] raw,
      input logic                      start);
    int unsigned        d;
    int unsigned        best;
    int unsigned        diff;
    int unsigned        cost;
    sgm_pkg::out_item_t res;
    d = disp_pos;
    // the start flag only counts on disparity zero
    if (d == 0) start_pixel = start;
    if (start_pixel) begin
      cost = raw;
    end else begin
      best = prior_costs[d];
      if (d > 0 && saved_lower + small_penalty < best)
        best = saved_lower + small_penalty;
      if (d + 1 < NDISP && prior_costs[d+1] + small_penalty < best)
        best = prior_costs[d+1] + small_penalty;
      if (prior_floor + large_penalty < best)
        best = prior_floor + large_penalty;
      diff = (best > prior_floor) ? best - prior_floor : 0;
      cost = raw + diff;
      if (cost > sgm_pkg::COST_MAX) cost = sgm_pkg::COST_MAX;
    end
    saved_lower    = prior_costs[d];
    prior_costs[d] = cost[sgm_pkg::COST_W-1:0];
    if (cost < pixel_floor) pixel_floor = cost[sgm_pkg::COST_W-1:0];
    res.path_cost       = cost[sgm_pkg::COST_W-1:0];
    res.disparity_index = d[sgm_pkg::IDX_W-1:0];
    res.pixel_done      = (d == NDISP - 1);
    if (d == NDISP - 1) begin
      prior_floor = pixel_floor;
      pixel_floor = sgm_pkg::COST_MAX;
      disp_pos    = 0;
    end else begin
      disp_pos = d + 1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // transaction monitor: one process sees both channels so the prediction of an
  // accepted cost is always queued before any result of the same edge is checked
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sgm_pkg::out_item_t want;
    if (!rst) begin
      if (raw_bus.valid && raw_bus.ready) begin
        expected_costs.push_back(predict_path_cost(raw_bus.match_cost,
                                                   raw_bus.path_start));
        costs_sent++;
      end
      if (path_bus.valid && path_bus.ready) begin
        if (expected_costs.size() == 0) begin
          $error("unexpected path cost transaction: cost %0d disparity %0d",
                 path_bus.path_cost, path_bus.disparity_index);
          errors++;
        end else begin
          want = expected_costs.pop_front();
          costs_checked++;
          if (path_bus.path_cost !== want.path_cost) begin
            $error("path_cost mismatch: expected %0d, actual %0d",
                   want.path_cost, path_bus.path_cost);
            errors++;
          end
          if (path_bus.disparity_index !== want.disparity_index) begin
            $error("disparity_index mismatch: expected %0d, actual %0d",
                   want.disparity_index, path_bus.disparity_index);
            errors++;
          end
          if (path_bus.pixel_done !== want.pixel_done) begin
            $error("pixel_done mismatch: expected %0d, actual %0d",
                   want.pixel_done, path_bus.pixel_done);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls, flat-out stretches and long hold-offs
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      path_bus.ready = 1'b0;
      hold_left--;
      stall_cycles++;
    end else if (no_gaps) begin
      path_bus.ready = 1'b1;
    end else begin
      path_bus.ready = ($urandom_range(0, 99) >= 23);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one raw cost, with random gaps before it, and wait until it is taken
  task automatic send_raw_cost(input logic [sgm_pkg::RAW_W-1:0] raw, input logic start);
    @(negedge clk);
    while (!no_gaps && $urandom_range(0, 99) < 23) begin
      raw_bus.valid      = 1'b0;
      raw_bus.match_cost = sgm_pkg::RAW_W'($urandom_range(0, 255));
      raw_bus.path_start = 1'($urandom_range(0, 1));
      @(posedge clk);
      @(negedge clk);
    end
    raw_bus.valid      = 1'b1;
    raw_bus.match_cost = raw;
    raw_bus.path_start = start;
    do @(posedge clk); while (!raw_bus.ready);
  endtask

  // one whole pixel, disparities 0..NDISP-1; stray start flags on later
  // disparities must be ignored by the block
  task automatic send_pixel(input pixel_shape_t shape, input logic start);
    int          center;
    int          slope;
    int          raw;
    int          level;
    logic        flag;
    center = $urandom_range(0, NDISP - 1);
    slope  = $urandom_range(1, 16);
    level  = $urandom_range(0, 255);
    if (start) start_pixels++;
    for (int d = 0; d < NDISP; d++) begin
      case (shape)
        SHAPE_UNIFORM:   raw = $urandom_range(0, 255);
        SHAPE_VALLEY: begin
          raw = ((d > center) ? d - center : center - d) * slope + $urandom_range(0, 15);
          if (raw > 255) raw = 255;
        end
        SHAPE_FLAT:      raw = level;
        SHAPE_ZERO:      raw = 0;
        SHAPE_FULL:      raw = 255;
        default:         raw = (d % 2) ? 255 : 0;
      endcase
      flag = (d == 0) ? start : ($urandom_range(0, 7) == 0);
      send_raw_cost(raw[sgm_pkg::RAW_W-1:0], flag);
    end
  endtask

  // stop offering, then wait for every outstanding result plus the output stage
  task automatic wait_drained();
    @(negedge clk);
    raw_bus.valid = 1'b0;
    while (expected_costs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_penalty(input sgm_pkg::cfg_reg_t idx,
                               input logic [sgm_pkg::CFG_D_W-1:0] value);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = value;
    @(negedge clk);
    wr_en    = 1'b0;
    wr_data  = sgm_pkg::CFG_D_W'($urandom_range(0, 1023));
    if (idx == sgm_pkg::REG_PENALTY_SMALL) small_penalty = value[sgm_pkg::P1_W-1:0];
    else                                   large_penalty = value[sgm_pkg::P2_W-1:0];
  endtask

  task automatic set_penalties(input int unsigned p1, input int unsigned p2);
    wait_drained();
    write_penalty(sgm_pkg::REG_PENALTY_SMALL, p1[sgm_pkg::CFG_D_W-1:0]);
    write_penalty(sgm_pkg::REG_PENALTY_LARGE, p2[sgm_pkg::CFG_D_W-1:0]);
  endtask

  function automatic pixel_shape_t random_shape();
    case ($urandom_range(0, 9))
      0, 1, 2:    return SHAPE_UNIFORM;
      3, 4, 5, 6: return SHAPE_VALLEY;
      7:          return SHAPE_FLAT;
      8:          return ($urandom_range(0, 1)) ? SHAPE_ZERO : SHAPE_FULL;
      default:    return SHAPE_ALTERNATE;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // penalties straight out of reset; the first pixel must open a path
  task automatic test_default_penalties();
    send_pixel(SHAPE_VALLEY, 1'b1);
    send_pixel(SHAPE_VALLEY, 1'b0);
  endtask

  // extreme raw costs: full-scale start, all-zero follower (large drops),
  // alternating extremes, then a restart in the middle of a path
  task automatic test_directed_edges();
    send_pixel(SHAPE_FULL, 1'b1);
    send_pixel(SHAPE_ZERO, 1'b0);
    send_pixel(SHAPE_ALTERNATE, 1'b0);
    send_pixel(SHAPE_FULL, 1'b1);
    send_pixel(SHAPE_ALTERNATE, 1'b0);
  endtask

  // penalty corners, each followed by a continuing pixel so both terms matter
  task automatic test_penalty_extremes();
    set_penalties(0, 0);
    send_pixel(SHAPE_UNIFORM, 1'b0);
    send_pixel(SHAPE_VALLEY, 1'b0);
    set_penalties(255, 1023);
    send_pixel(SHAPE_ALTERNATE, 1'b0);
    send_pixel(SHAPE_FULL, 1'b0);
    set_penalties(0, 1023);
    send_pixel(SHAPE_VALLEY, 1'b0);
    set_penalties(255, 0);
    send_pixel(SHAPE_UNIFORM, 1'b0);
    set_penalties(1, 2);
    send_pixel(SHAPE_VALLEY, 1'b0);
  endtask

  // long stream of mostly continuing pixels with occasional path restarts;
  // penalties change between chunks, upper data bits of the small penalty
  // write carry junk that must be dropped
  task automatic test_random_paths();
    for (int chunk = 0; chunk < 5; chunk++) begin
      wait_drained();
      write_penalty(sgm_pkg::REG_PENALTY_SMALL,
                    sgm_pkg::CFG_D_W'($urandom_range(0, 1023)));
      write_penalty(sgm_pkg::REG_PENALTY_LARGE,
                    sgm_pkg::CFG_D_W'($urandom_range(0, 1023)));
      // one chunk runs with no gaps on either side
      no_gaps = (chunk == 2);
      for (int px = 0; px < 3; px++)
        send_pixel(random_shape(), $urandom_range(0, 7) == 0);
    end
    no_gaps = 1'b0;
    wait_drained();
    write_penalty(sgm_pkg::REG_PENALTY_SMALL, sgm_pkg::CFG_D_W'(10));
    write_penalty(sgm_pkg::REG_PENALTY_LARGE, sgm_pkg::CFG_D_W'(120));
  endtask

  // receiver holds off long enough that the output stage fills and the input
  // stalls, while the sender keeps offering
  task automatic test_output_backpressure();
    wait_drained();
    hold_request = 300;
    send_pixel(SHAPE_VALLEY, 1'b0);
    send_pixel(SHAPE_UNIFORM, 1'b0);
    hold_request = 150;
    send_pixel(SHAPE_VALLEY, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = sgm_pkg::REG_PENALTY_SMALL;
    wr_data            = '0;
    raw_bus.valid      = 1'b0;
    raw_bus.match_cost = '0;
    raw_bus.path_start = 1'b0;
    path_bus.ready     = 1'b0;
    no_gaps            = 1'b0;
    hold_request       = 0;
    hold_left          = 0;
    errors             = 0;
    costs_sent         = 0;
    costs_checked      = 0;
    start_pixels       = 0;
    stall_cycles       = 0;
    clear_predictor();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_penalties();
    test_directed_edges();
    test_penalty_extremes();
    test_random_paths();
    test_output_backpressure();

    // drain and let the output stage show any strays
    wait_drained();
    repeat (8) @(posedge clk);
    if (expected_costs.size() != 0) begin
      $error("%0d path costs never arrived", expected_costs.size());
      errors++;
    end

    $display("covered %0d raw costs, %0d path costs checked, %0d path starts",
             costs_sent, costs_checked, start_pixels);
    $display("penalty corners and random settings, %0d receiver hold-off cycles",
             stall_cycles);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // watchdog: about 2000 transactions should finish well below 0.5 ms; 3 ms
  // leaves a wide margin
  initial begin
    #3_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/sgm_pkg.sv
src/sgm_stream_if.sv
src/sgm_cell.sv
src/sgm_cost_unit.sv
src/sgm_out_skid.sv
src/sgm_path_cost_aggregation.sv
test/tb.sv
